/* hw/rtl/encoder_button_manual_level_control_core_macros.svh */
// Assertion helpers for the manual level control block.
`ifndef ENCODER_BUTTON_MANUAL_LEVEL_CONTROL_CORE_MACROS_SVH
`define ENCODER_BUTTON_MANUAL_LEVEL_CONTROL_CORE_MACROS_SVH

// same-cycle implication, off while reset is low
`define EBML_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ebml assertion failed: same-cycle implication");

// next-cycle implication, off while reset is low
`define EBML_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ebml assertion failed: next-cycle implication");

`endif

/* hw/rtl/ebml_pkg.sv */
`default_nettype none

package ebml_pkg;

    localparam int unsigned TS_W      = 32;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned RPM_W     = 16;
    localparam int unsigned LVL_W     = 16;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    // x100 grows a step by under 7 bits; one more bit for the add
    localparam int unsigned SCL_W     = POS_W + 7;
    localparam int unsigned SUM_W     = SCL_W + 1;

    localparam logic [RPM_W-1:0] RPM_FINE_LOW  = 16'd100;
    localparam logic [RPM_W-1:0] RPM_FINE_HIGH = 16'd500;
    localparam logic [RPM_W-1:0] RPM_COARSE    = 16'd1000;

    localparam logic [CFG_W-1:0] DAC_MAX_RST       = 16'd4095;
    localparam logic [CFG_W-1:0] RELEASE_GUARD_RST = 16'd100;
    localparam logic [CFG_W-1:0] HOLD_RST          = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DAC_MAX       = 2'd0,
        CFG_RELEASE_GUARD = 2'd1,
        CFG_HOLD          = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic click;
        logic hold;
    } t_sw_evt;

    typedef struct packed {
        logic             manual_mode;
        logic [LVL_W-1:0] drive_level;
        logic             routine_started;
        logic [TS_W-1:0]  routine_start_ms;
    } t_res;

endpackage

`default_nettype wire

/* hw/rtl/ebml_smp_if.sv */
`default_nettype none

interface ebml_smp_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        switch_pressed;
    logic signed [31:0] encoder_position;
    logic [15:0] encoder_rpm;

    modport source (
        output valid, now_ms, switch_pressed, encoder_position, encoder_rpm,
        input  ready
    );
    modport sink (
        input  valid, now_ms, switch_pressed, encoder_position, encoder_rpm,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/ebml_res_if.sv */
`default_nettype none

interface ebml_res_if;
    logic        valid;
    logic        ready;
    logic        manual_mode;
    logic [15:0] drive_level;
    logic        routine_started;
    logic [31:0] routine_start_ms;

    modport source (
        output valid, manual_mode, drive_level, routine_started, routine_start_ms,
        input  ready
    );
    modport sink (
        input  valid, manual_mode, drive_level, routine_started, routine_start_ms,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/ebml_switch.sv */
`default_nettype none

// Switch press/release tracking; flags click or hold on a qualified release.
module ebml_switch (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [ebml_pkg::TS_W-1:0]   i_now,
    input  logic                        i_pressed,
    input  logic [ebml_pkg::CFG_W-1:0]  i_release_guard_ms,
    input  logic [ebml_pkg::CFG_W-1:0]  i_hold_ms,
    output ebml_pkg::t_sw_evt           o_evt
);
    import ebml_pkg::*;

    logic [TS_W-1:0] r_press_time;
    logic [TS_W-1:0] r_release_time;
    logic [TS_W-1:0] n_press_time;
    logic [TS_W-1:0] n_release_time;
    logic [TS_W-1:0] rel_age;
    logic [TS_W-1:0] press_age;
    logic            take_press;
    logic            take_release;
    logic            is_hold;

    always_comb begin
        // ages wrap mod 2^32
        rel_age      = i_now - r_release_time;
        press_age    = i_now - r_press_time;
        take_press   = i_pressed && (r_release_time >= r_press_time)
                       && (rel_age >= {{(TS_W-CFG_W){1'b0}}, i_release_guard_ms});
        take_release = !i_pressed && (r_press_time > r_release_time);
        is_hold      = press_age > {{(TS_W-CFG_W){1'b0}}, i_hold_ms};

        n_press_time   = take_press   ? i_now : r_press_time;
        n_release_time = take_release ? i_now : r_release_time;

        o_evt.click = take_release && !is_hold;
        o_evt.hold  = take_release && is_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_time   <= '0;
            r_release_time <= '0;
        end else if (i_en) begin
            r_press_time   <= n_press_time;
            r_release_time <= n_release_time;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ebml_level.sv */
`default_nettype none

// Manual mode toggle and scaled, saturated drive level.
module ebml_level (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [ebml_pkg::TS_W-1:0]         i_now,
    input  logic signed [ebml_pkg::POS_W-1:0] i_pos,
    input  logic [ebml_pkg::RPM_W-1:0]        i_rpm,
    input  ebml_pkg::t_sw_evt                 i_evt,
    input  logic [ebml_pkg::CFG_W-1:0]        i_dac_max,
    output ebml_pkg::t_res                    o_res
);
    import ebml_pkg::*;

    logic signed [POS_W-1:0] r_last_pos;
    logic                    r_manual;
    logic [LVL_W-1:0]        r_level;
    logic [TS_W-1:0]         r_start_ms;
    logic                    n_manual;
    logic [LVL_W-1:0]        n_level;
    logic [TS_W-1:0]         n_start_ms;
    logic                    left;

    logic signed [POS_W-1:0] step;
    logic signed [SCL_W-1:0] step_ext;
    logic signed [SCL_W-1:0] step_x10;
    logic signed [SCL_W-1:0] step_x100;
    logic signed [SCL_W-1:0] scaled;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] dac_ext;
    logic [LVL_W-1:0]        clamped;
    logic                    moved;
    logic                    fine;
    logic                    coarse;

    always_comb begin
        moved    = (i_pos != r_last_pos);
        step     = i_pos - r_last_pos;  // zero when not moved
        step_ext = {{(SCL_W-POS_W){step[POS_W-1]}}, step};
        // constant scales as shift-add
        step_x10  = (step_ext <<< 3) + (step_ext <<< 1);
        step_x100 = (step_ext <<< 6) + (step_ext <<< 5) + (step_ext <<< 2);
        fine   = (i_rpm >= RPM_FINE_LOW) && (i_rpm < RPM_FINE_HIGH);
        coarse = (i_rpm >= RPM_COARSE);
        if (fine) begin
            scaled = step_x10;
        end else if (coarse) begin
            scaled = step_x100;
        end else begin
            scaled = step_ext;
        end

        sum     = $signed({{(SUM_W-LVL_W){1'b0}}, r_level}) + $signed({scaled[SCL_W-1], scaled});
        dac_ext = $signed({{(SUM_W-CFG_W){1'b0}}, i_dac_max});
        if (sum > dac_ext) begin
            clamped = i_dac_max;
        end else if (sum[SUM_W-1]) begin
            clamped = '0;
        end else begin
            clamped = sum[LVL_W-1:0];
        end

        n_manual   = r_manual;
        n_level    = r_level;
        n_start_ms = r_start_ms;
        left       = 1'b0;
        if (moved || i_evt.click || i_evt.hold) begin
            if (r_manual) begin
                if (i_evt.click) begin
                    n_manual   = 1'b0;
                    n_start_ms = i_now;
                    left       = 1'b1;
                end else begin
                    n_level = clamped;
                end
            end else if (i_evt.click) begin
                n_manual = 1'b1;
            end
        end

        o_res.manual_mode      = n_manual;
        o_res.drive_level      = n_level;
        o_res.routine_started  = left;
        o_res.routine_start_ms = n_start_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos <= '0;
            r_manual   <= 1'b0;
            r_level    <= '0;
            r_start_ms <= '0;
        end else if (i_en) begin
            r_last_pos <= i_pos;
            r_manual   <= n_manual;
            r_level    <= n_level;
            r_start_ms <= n_start_ms;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/encoder_button_manual_level_control_core.sv */
// The request is registered in the input stage, then its result in the result register.
// Throughput: one request per cycle while results are taken; the state update fits between the two registers.
// The input register takes a new request while a result waits, as long as it is empty or its request moves on.
// Reset (synchronous, active low): state cleared to zero, registers to their defaults,
// both pipeline stages emptied.
`default_nettype none

module encoder_button_manual_level_control_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ebml_smp_if.sink                         i_smp,
    ebml_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [ebml_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ebml_pkg::CFG_W-1:0]       i_cfg_data
);
    import ebml_pkg::*;

    // config registers
    logic [CFG_W-1:0] r_dac_max;
    logic [CFG_W-1:0] r_release_guard_ms;
    logic [CFG_W-1:0] r_hold_ms;

    // input stage
    logic                    r_s1_vld;
    logic [TS_W-1:0]         r_s1_now;
    logic                    r_s1_pressed;
    logic signed [POS_W-1:0] r_s1_pos;
    logic [RPM_W-1:0]        r_s1_rpm;

    // result stage
    logic                    r_out_vld;
    t_res                    r_out;

    logic    in_acc;
    logic    s1_adv;
    t_sw_evt sw_evt;
    t_res    res_next;

    // stage 1 moves on when the result slot is free or being drained
    assign s1_adv      = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_smp.ready = !r_s1_vld || s1_adv;
    assign in_acc      = i_smp.valid && i_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dac_max          <= DAC_MAX_RST;
            r_release_guard_ms <= RELEASE_GUARD_RST;
            r_hold_ms          <= HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DAC_MAX:       r_dac_max          <= i_cfg_data;
                CFG_RELEASE_GUARD: r_release_guard_ms <= i_cfg_data;
                CFG_HOLD:          r_hold_ms          <= i_cfg_data;
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_now     <= i_smp.now_ms;
            r_s1_pressed <= i_smp.switch_pressed;
            r_s1_pos     <= i_smp.encoder_position;
            r_s1_rpm     <= i_smp.encoder_rpm;
        end
    end

    // switch events from the request in stage 1
    ebml_switch u_switch (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (s1_adv),
        .i_now              (r_s1_now),
        .i_pressed          (r_s1_pressed),
        .i_release_guard_ms (r_release_guard_ms),
        .i_hold_ms          (r_hold_ms),
        .o_evt              (sw_evt)
    );

    // mode and level; its state commits together with the result register
    ebml_level u_level (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (s1_adv),
        .i_now     (r_s1_now),
        .i_pos     (r_s1_pos),
        .i_rpm     (r_s1_rpm),
        .i_evt     (sw_evt),
        .i_dac_max (r_dac_max),
        .o_res     (res_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= res_next;
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.manual_mode      = r_out.manual_mode;
    assign o_res.drive_level      = r_out.drive_level;
    assign o_res.routine_started  = r_out.routine_started;
    assign o_res.routine_start_ms = r_out.routine_start_ms;

endmodule

`default_nettype wire

/* hw/rtl/ebml_chk.sv */
`default_nettype none

`include "encoder_button_manual_level_control_core_macros.svh"

// Port-level checks on the core.
module ebml_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_manual_mode,
    input logic [15:0] i_drive_level,
    input logic        i_routine_started,
    input logic [31:0] i_routine_start_ms
);

    // stalled result holds
    `EBML_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_manual_mode) && $stable(i_drive_level) && $stable(i_routine_started) && $stable(i_routine_start_ms))

    // leaving manual mode leaves it off
    `EBML_ASSERT_IMPLY(a_left_off, i_clk, i_rst_n, i_out_valid && i_routine_started, !i_manual_mode)

    // nothing shown right after reset
    `EBML_ASSERT_IMPLY(a_rst_empty, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid)

endmodule

bind encoder_button_manual_level_control_core ebml_chk u_ebml_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_res.valid),
    .i_out_ready        (o_res.ready),
    .i_manual_mode      (o_res.manual_mode),
    .i_drive_level      (o_res.drive_level),
    .i_routine_started  (o_res.routine_started),
    .i_routine_start_ms (o_res.routine_start_ms)
);

`default_nettype wire

/* verif/tb_encoder_button_manual_level_control_core.sv */
// Testbench for the encoder switch / manual drive-level block.
//
// Polling samples are pushed into a queue by the stimulus process and
// replayed onto the sample channel by a clocked driver with random gaps.
// Every accepted request runs through a local predictor of the block,
// and its outcome is queued. The monitor pops one outcome per accepted
// result and compares all four result fields.
// Settings change only between phases, once every outcome has been
// checked and the pipeline has had time to empty.
`default_nettype none

module tb_encoder_button_manual_level_control_core;
    import ebml_pkg::*;

    localparam int          CLK_PERIOD   = 4;
    localparam int          MAX_CYCLES   = 2_000_000;
    localparam longint      SCALE_FINE   = 10;
    localparam longint      SCALE_COARSE = 100;
    // receiver hold-off long enough to back the block up into the sender
    localparam int unsigned HOLD_OFF_LEN = 300;

    typedef struct packed {
        logic [TS_W-1:0]  now_ms;
        logic             pressed;
        logic [POS_W-1:0] pos;
        logic [RPM_W-1:0] rpm;
    } t_sample;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ebml_smp_if smp ();
    ebml_res_if res ();

    encoder_button_manual_level_control_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: settings and the block's state as seen after the
    // last accepted sample.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_dac   = DAC_MAX_RST;
    logic [CFG_W-1:0] cfg_guard = RELEASE_GUARD_RST;
    logic [CFG_W-1:0] cfg_hold  = HOLD_RST;

    logic [TS_W-1:0]  lc_press_t  = '0;
    logic [TS_W-1:0]  lc_rel_t    = '0;
    logic [POS_W-1:0] lc_last_pos = '0;
    logic             lc_manual   = 1'b0;
    logic [LVL_W-1:0] lc_level    = '0;
    logic [TS_W-1:0]  lc_start    = '0;

    t_sample     sample_q[$];      // samples still to be offered
    t_res        ctl_outcome_q[$]; // predicted results, oldest first
    int unsigned n_queued = 0;
    int unsigned n_done   = 0;
    int unsigned n_fail   = 0;

    // stimulus-side cursors: last queued time and position; time only moves forward in the gesture phases
    logic [TS_W-1:0]  t_cur      = '0;
    logic [TS_W-1:0]  t_rel_last = '0;
    logic [POS_W-1:0] pos_cur    = '0;
    int               pos_bias   = 0;

    logic        src_nogap    = 1'b0;
    logic        sink_nogap   = 1'b0;
    logic        hold_off_req = 1'b0;
    int unsigned hold_off_cnt;
    int unsigned src_gap;
    int unsigned rdy_gap;
    t_sample     drv_item;
    t_sample     seen;
    t_res        want;

    // One polling sample through the switch and level logic.
    function automatic t_res step_level_ctl(t_sample s);
        t_res        r;
        logic [31:0] pos_diff;
        logic [31:0] since_rel;
        logic [31:0] held;
        logic        moved;
        logic        click;
        logic        was_hold;
        logic        left;
        longint      step;
        longint      sum;
        click    = 1'b0;
        was_hold = 1'b0;
        left     = 1'b0;
        step     = 0;

        // movement: wrapped difference read as signed, zero if no move
        moved = (s.pos != lc_last_pos);
        if (moved) begin
            pos_diff    = s.pos - lc_last_pos;
            step        = $signed(pos_diff);
            lc_last_pos = s.pos;
        end

        // press counts only after a release that is not older than the
        // last press, and only once the release guard has run out
        since_rel = s.now_ms - lc_rel_t;
        if (s.pressed && lc_rel_t >= lc_press_t && since_rel >= 32'(cfg_guard)) begin
            lc_press_t = s.now_ms;
        end else if (!s.pressed && lc_press_t > lc_rel_t) begin
            lc_rel_t = s.now_ms;
            held     = s.now_ms - lc_press_t;
            if (held > 32'(cfg_hold)) begin
                was_hold = 1'b1;
            end else begin
                click = 1'b1;
            end
        end

        if (moved || click || was_hold) begin
            if (lc_manual) begin
                if (click) begin
                    lc_manual = 1'b0;
                    lc_start  = s.now_ms;
                    left      = 1'b1;
                end else begin
                    // 500..999 rpm is deliberately left unscaled
                    if (s.rpm >= RPM_FINE_LOW && s.rpm < RPM_FINE_HIGH) begin
                        step = step * SCALE_FINE;
                    end else if (s.rpm >= RPM_COARSE) begin
                        step = step * SCALE_COARSE;
                    end
                    sum = longint'(lc_level) + step;
                    if (sum > longint'(cfg_dac)) begin
                        sum = longint'(cfg_dac);
                    end else if (sum < 0) begin
                        sum = 0;
                    end
                    lc_level = 16'(sum);
                end
            end else if (click) begin
                lc_manual = 1'b1;
            end
        end

        r.manual_mode      = lc_manual;
        r.drive_level      = lc_level;
        r.routine_started  = left;
        r.routine_start_ms = lc_start;
        return r;
    endfunction

    // mostly back-to-back, some short pauses, a few long ones
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // speed bands plus their edges
    function automatic logic [RPM_W-1:0] pick_rpm();
        logic [RPM_W-1:0] edges[8];
        edges = '{16'd0, 16'd99, 16'd100, 16'd499, 16'd500, 16'd999, 16'd1000, 16'hFFFF};
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 99));
            1: return 16'($urandom_range(100, 499));
            2: return 16'($urandom_range(500, 999));
            3: return 16'($urandom_range(1000, 65535));
            4: return edges[$urandom_range(0, 7)];
            default: return 16'($urandom_range(1000, 2000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: holds a request until accepted, then idles for the
    // chosen gap before offering the next one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
            src_gap   <= 0;
        end else if (!smp.valid || smp.ready) begin
            if (src_gap != 0) begin
                smp.valid <= 1'b0;
                src_gap   <= src_gap - 1;
            end else if (sample_q.size() != 0) begin
                drv_item = sample_q.pop_front();
                smp.valid            <= 1'b1;
                smp.now_ms           <= drv_item.now_ms;
                smp.switch_pressed   <= drv_item.pressed;
                smp.encoder_position <= drv_item.pos;
                smp.encoder_rpm      <= drv_item.rpm;
                src_gap              <= src_nogap ? 0 : gap_len();
            end else begin
                smp.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here so the sender keeps going
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off_cnt <= 0;
        end else if (hold_off_req) begin
            hold_off_cnt <= HOLD_OFF_LEN;
        end else if (hold_off_cnt != 0) begin
            hold_off_cnt <= hold_off_cnt - 1;
        end
    end

    // result receiver: random stalls unless told to run flat out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            rdy_gap   <= 0;
        end else if (hold_off_cnt != 0) begin
            res.ready <= 1'b0;
        end else if (rdy_gap != 0) begin
            res.ready <= 1'b0;
            rdy_gap   <= rdy_gap - 1;
        end else begin
            res.ready <= 1'b1;
            if (!sink_nogap) begin
                rdy_gap <= gap_len();
            end
        end
    end

    task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, exp_v, got_v);
            n_fail++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: results are checked before the request of the same edge is
    // predicted; the input and result stages keep each result behind its request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                n_done++;
                if (ctl_outcome_q.size() == 0) begin
                    $display("%0t: result with nothing outstanding: expected none, got %0h",
                             $time, {res.manual_mode, res.drive_level,
                                     res.routine_started, res.routine_start_ms});
                    n_fail++;
                end else begin
                    want = ctl_outcome_q.pop_front();
                    check_field("manual_mode", 32'(want.manual_mode), 32'(res.manual_mode));
                    check_field("drive_level", 32'(want.drive_level), 32'(res.drive_level));
                    check_field("routine_started", 32'(want.routine_started),
                                32'(res.routine_started));
                    check_field("routine_start_ms", want.routine_start_ms, res.routine_start_ms);
                end
            end
            if (smp.valid && smp.ready) begin
                seen.now_ms  = smp.now_ms;
                seen.pressed = smp.switch_pressed;
                seen.pos     = smp.encoder_position;
                seen.rpm     = smp.encoder_rpm;
                ctl_outcome_q.push_back(step_level_ctl(seen));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(logic [31:0] t, logic p, logic [31:0] pos, logic [15:0] rpm);
        t_sample s;
        s.now_ms = t;
        s.pressed = p;
        s.pos = pos;
        s.rpm = rpm;
        t_cur   = t;
        pos_cur = pos;
        sample_q.push_back(s);
        n_queued++;
    endtask

    // sample on the time cursor; a few turn into noise with a random
    // switch level, speed and position
    task automatic push_sample(logic [31:0] t, logic p);
        int move;
        if ($urandom_range(0, 99) < 8) begin
            push_item(t, 1'($urandom_range(0, 1)), $urandom, 16'($urandom_range(0, 65535)));
        end else begin
            move = ($urandom_range(0, 9) < 3) ? 0 : int'($urandom_range(0, 40)) - 20 + pos_bias;
            push_item(t, p, pos_cur + 32'(move), pick_rpm());
        end
    endtask

    // idle samples, a press placed around the release guard, a press
    // length around the hold time, and usually a release
    task automatic push_gesture();
        logic [31:0] press_t;
        logic [31:0] rel_t;
        logic [31:0] t;
        int unsigned guard_gap;
        int unsigned held_t;
        int unsigned n_idle;
        n_idle = $urandom_range(0, 3);
        case ($urandom_range(0, 9))
            0: begin
                guard_gap = (cfg_guard == 0) ? 0 : cfg_guard - 1;
                n_idle    = 0;
            end
            1: begin
                guard_gap = cfg_guard;
                n_idle    = 0;
            end
            default: guard_gap = cfg_guard + $urandom_range(1, 50);
        endcase
        repeat (n_idle) push_sample(t_cur + $urandom_range(0, 20), 1'b0);
        press_t = t_rel_last + guard_gap;
        if (press_t < t_cur) begin
            press_t = t_cur;
        end
        push_sample(press_t, 1'b1);

        case ($urandom_range(0, 4))
            0: held_t = (cfg_hold == 0) ? 0 : cfg_hold - 1;
            1: held_t = cfg_hold;
            2: held_t = cfg_hold + 1;
            3: held_t = $urandom_range(0, cfg_hold);
            default: held_t = cfg_hold + $urandom_range(1, 500);
        endcase
        rel_t = press_t + held_t;
        repeat ($urandom_range(0, 3)) begin
            t = t_cur + $urandom_range(0, 20);
            if (t > rel_t) begin
                t = rel_t;
            end
            push_sample(t, 1'b1);
        end
        // now and then the switch stays down into the next gesture
        if ($urandom_range(0, 9) != 0) begin
            push_sample(rel_t, 1'b0);
            t_rel_last = rel_t;
        end
    endtask

    task automatic queue_gestures(int unsigned n);
        int unsigned first;
        first = n_queued;
        while (n_queued - first < n) push_gesture();
    endtask

    // sender pause: every queued request must have its result checked,
    // then a few cycles for the two pipeline stages
    task automatic wait_idle();
        do @(posedge i_clk);
        while (n_done != n_queued);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_settings(logic [15:0] dac, logic [15:0] guard, logic [15:0] hold_v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DAC_MAX;
        i_cfg_data <= dac;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RELEASE_GUARD;
        i_cfg_data <= guard;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HOLD;
        i_cfg_data <= hold_v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_dac   = dac;
        cfg_guard = guard;
        cfg_hold  = hold_v;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        smp.valid            = 1'b0;
        smp.now_ms           = '0;
        smp.switch_pressed   = 1'b0;
        smp.encoder_position = '0;
        smp.encoder_rpm      = '0;
        res.ready            = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_DAC_MAX;
        i_cfg_data           = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on reset settings (dac 4095, guard 100, hold 1000).
        push_item(32'd0,    1'b0, 32'd0, 16'd0);          // idle sample
        push_item(32'd50,   1'b1, 32'd0, 16'd0);          // inside release guard
        push_item(32'd200,  1'b1, 32'd0, 16'd0);          // press taken
        push_item(32'd300,  1'b0, 32'd0, 16'd0);          // click: enter manual
        push_item(32'd310,  1'b0, 32'd5, 16'd0);          // slow: unscaled
        push_item(32'd320,  1'b0, 32'd15, 16'd100);       // fine band low edge
        push_item(32'd330,  1'b0, 32'd14, 16'd499);       // fine band, step down
        push_item(32'd340,  1'b0, 32'd24, 16'd500);       // dead band low edge
        push_item(32'd350,  1'b0, 32'd25, 16'd999);       // dead band high edge
        push_item(32'd360,  1'b0, 32'd26, 16'd1000);      // coarse band
        push_item(32'd370,  1'b0, 32'h7FFF_FFFF, 16'hFFFF); // top clamp
        push_item(32'd380,  1'b0, 32'h8000_0000, 16'd0);  // position wraps by one
        push_item(32'd390,  1'b0, 32'd0, 16'hFFFF);       // most negative step, floor
        push_item(32'd500,  1'b1, 32'd0, 16'd0);
        push_item(32'd2000, 1'b0, 32'd0, 16'd0);          // hold: stays manual
        push_item(32'd2100, 1'b1, 32'd0, 16'd0);          // guard met exactly
        push_item(32'd3100, 1'b0, 32'd0, 16'd0);          // hold time exactly: click, leave
        push_item(32'd3110, 1'b0, 32'd1000, 16'd2000);    // movement outside manual
        push_item(32'd3120, 1'b1, 32'd1000, 16'd0);       // guard not met
        push_item(32'd3300, 1'b0, 32'd1000, 16'd0);       // release with no press
        t_rel_last = 32'd3100;
        wait_idle();

        // widest level range, no guard, zero hold time
        write_settings(16'hFFFF, 16'd0, 16'd0);
        queue_gestures(350);
        wait_idle();

        // level pinned at zero, longest guard and hold
        write_settings(16'd0, 16'hFFFF, 16'hFFFF);
        queue_gestures(250);
        wait_idle();

        // receiver holds off while the sender keeps offering requests
        write_settings(16'd1000, 16'd50, 16'd300);
        src_nogap = 1'b1;
        queue_gestures(300);
        @(posedge i_clk);
        hold_off_req <= 1'b1;
        @(posedge i_clk);
        hold_off_req <= 1'b0;
        wait_idle();
        src_nogap = 1'b0;

        // no idling on either side; position drifts up to raise the level
        write_settings(16'hFFFF, 16'd20, 16'd500);
        src_nogap  = 1'b1;
        sink_nogap = 1'b1;
        pos_bias   = 15;
        queue_gestures(300);
        wait_idle();
        src_nogap  = 1'b0;
        sink_nogap = 1'b0;
        pos_bias   = 0;

        // lowered ceiling: a level above it gets clamped on the next movement or hold in manual mode
        write_settings(16'd100, 16'd100, 16'd1000);
        queue_gestures(300);
        wait_idle();

        write_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 300)),
                       16'($urandom_range(0, 2000)));
        queue_gestures(300);
        wait_idle();

        // Time stamp wrap last: a press stamped above the release blocks later presses
        // until a release is stamped at least as high, so nothing well-formed follows it.
        write_settings(DAC_MAX_RST, RELEASE_GUARD_RST, HOLD_RST);
        push_item(t_cur + 32'd10, 1'b0, pos_cur, 16'd0);  // end any open press
        push_item(32'hFFFF_FFF0,  1'b1, pos_cur, 16'd0);
        push_item(32'h0000_0010,  1'b0, pos_cur, 16'd0);  // click across the wrap
        push_item(32'h0000_0020,  1'b0, pos_cur, 16'd0);  // stale press clicks again
        push_item(32'h0000_0100,  1'b1, pos_cur, 16'd0);  // release older than press
        push_item(32'hFFFF_FFFF,  1'b0, pos_cur, 16'd0);
        repeat (150) begin
            push_item($urandom, 1'($urandom_range(0, 1)), $urandom,
                      16'($urandom_range(0, 65535)));
        end
        wait_idle();

        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * MAX_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
